### design/pixel_tone_map_gamma_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for pixel_tone_map_gamma
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TONE_MAP_GAMMA_MACROS_SVH
`define PIXEL_TONE_MAP_GAMMA_MACROS_SVH

// Same-cycle implication.
`define PTMG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ptmg_pkg.sv
// ----------------------------------------------------------------------------
// ptmg_pkg
// Widths, stage counts, register codes and the exp2 factor table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptmg_pkg;

  // Component format.
  localparam int FracW  = 16;
  localparam int IntW   = 8;
  localparam int CompW  = IntW + FracW;
  localparam int ValW   = FracW + 1;
  localparam int LevelW = 8;
  localparam int PosW   = $clog2(FracW);

  // Log/exp datapath.
  localparam int QW     = 30;
  localparam int MantW  = QW + 1;
  localparam int LogW   = 16;
  localparam int LgW    = LogW + PosW + 1;
  localparam int ExpW   = 16;
  localparam int ProdW  = LgW + ExpW - 12;
  localparam int IpW    = ProdW - LogW;
  localparam int ShW    = 5;

  // Pipeline lengths.
  localparam int DivSteps   = ValW;
  localparam int NormStages = DivSteps + 1;
  localparam int PowStages  = 1 + LogW + 1 + 1 + LogW + 1;
  localparam int PipeDepth  = NormStages + PowStages + 1;

  localparam logic [ValW-1:0]  Unit     = {1'b1, {FracW{1'b0}}};
  localparam logic [CompW-1:0] UnitComp = CompW'(Unit);
  localparam logic [MantW-1:0] OneQ     = {1'b1, {QW{1'b0}}};
  localparam logic [ExpW-1:0]  InvGammaReset = ExpW'(4096);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegShowOog  = 2'd0,
    RegGammaEn  = 2'd1,
    RegInvGamma = 2'd2
  } reg_idx_e;

  // How the normalizer treats a pixel.
  typedef enum logic [1:0] {
    NormPass = 2'd0,
    NormRed  = 2'd1,
    NormDiv  = 2'd2
  } norm_mode_e;

  typedef struct packed {
    logic            show_oog;
    logic            gamma_en;
    logic [ExpW-1:0] gamma_exp;
  } cfg_t;

  typedef logic [LogW-1:0][MantW-1:0] fac_arr_t;

  // Integer square root by the digit-pair method, elaboration time only.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = x;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Factors 2^-(2^-k) in Q30 for k = 1..16.
  function automatic fac_arr_t fac_table();
    fac_arr_t    t;
    logic [63:0] prev;
    prev = isqrt64(64'd1 << 59);
    t[0] = MantW'(prev);
    for (int k = 1; k < LogW; k++) begin
      prev = isqrt64(prev << QW);
      t[k] = MantW'(prev);
    end
    return t;
  endfunction

  localparam fac_arr_t FacTable = fac_table();

endpackage

`default_nettype wire

### design/ptmg_norm.sv
// ----------------------------------------------------------------------------
// ptmg_norm
// Max search, gamut handling and a one-bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmg_norm import ptmg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire cfg_t             cfg_i,
  input  wire logic [CompW-1:0] red_i,
  input  wire logic [CompW-1:0] green_i,
  input  wire logic [CompW-1:0] blue_i,
  output logic      [ValW-1:0]  red_o,
  output logic      [ValW-1:0]  green_o,
  output logic      [ValW-1:0]  blue_o
);

  typedef struct packed {
    norm_mode_e                 mode;
    logic [CompW-1:0]           dvs;
    logic [2:0]                 lsb;
    logic [2:0][CompW-1:0]      rem;
    logic [2:0][ValW-1:0]       quo;
  } div_stage_t;

  div_stage_t st_q [NormStages];
  div_stage_t st_d [NormStages];

  // One quotient bit per component.
  function automatic div_stage_t div_step(input div_stage_t s, input logic first);
    div_stage_t     n;
    logic [CompW:0] t;
    n = s;
    if (s.mode == NormDiv) begin
      for (int i = 0; i < 3; i++) begin
        t = {s.rem[i], first & s.lsb[i]};
        if (t >= {1'b0, s.dvs}) begin
          n.rem[i] = CompW'(t - {1'b0, s.dvs});
          n.quo[i] = {s.quo[i][ValW-2:0], 1'b1};
        end else begin
          n.rem[i] = t[CompW-1:0];
          n.quo[i] = {s.quo[i][ValW-2:0], 1'b0};
        end
      end
    end
    return n;
  endfunction

  // Load stage: largest component, mode and divider start values.
  always_comb begin
    logic [2:0][CompW-1:0] c;
    logic [CompW-1:0]      mx;
    c  = {blue_i, green_i, red_i};
    mx = c[0];
    if (c[1] > mx) mx = c[1];
    if (c[2] > mx) mx = c[2];
    st_d[0].dvs = mx;
    if (mx > UnitComp) begin
      st_d[0].mode = cfg_i.show_oog ? NormRed : NormDiv;
    end else begin
      st_d[0].mode = NormPass;
    end
    for (int i = 0; i < 3; i++) begin
      st_d[0].lsb[i] = c[i][0];
      st_d[0].rem[i] = {1'b0, c[i][CompW-1:1]};
      case (st_d[0].mode)
        NormPass: st_d[0].quo[i] = c[i][ValW-1:0];
        NormRed:  st_d[0].quo[i] = (i == 0) ? Unit : '0;
        default:  st_d[0].quo[i] = '0;
      endcase
    end
    for (int j = 0; j < DivSteps; j++) begin
      st_d[j+1] = div_step(st_q[j], j == 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign red_o   = st_q[NormStages-1].quo[0];
  assign green_o = st_q[NormStages-1].quo[1];
  assign blue_o  = st_q[NormStages-1].quo[2];

endmodule

`default_nettype wire

### design/ptmg_power.sv
// ----------------------------------------------------------------------------
// ptmg_power
// Pipelined power law v^e: squaring log2, exponent multiply, factor exp2.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmg_power import ptmg_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire cfg_t            cfg_i,
  input  wire logic [ValW-1:0] val_i,
  output logic      [ValW-1:0] val_o
);

  typedef struct packed {
    logic             byp;
    logic [ValW-1:0]  bval;
    logic [PosW-1:0]  pos;
    logic [MantW-1:0] m;
    logic [LogW-1:0]  f;
  } log_stage_t;

  typedef struct packed {
    logic            byp;
    logic [ValW-1:0] bval;
    logic [LgW-1:0]  lg;
  } mid_stage_t;

  typedef struct packed {
    logic             byp;
    logic [ValW-1:0]  bval;
    logic [IpW-1:0]   ip;
    logic [LogW-1:0]  fp;
    logic [MantW-1:0] r;
  } exp_stage_t;

  log_stage_t      lq_q [LogW+1];
  log_stage_t      lq_d [LogW+1];
  mid_stage_t      mid_q, mid_d;
  exp_stage_t      ex_q [LogW+1];
  exp_stage_t      ex_d [LogW+1];
  logic [ValW-1:0] out_q, out_d;

  always_comb begin
    logic [MantW+FracW-1:0] wide;
    logic [2*MantW-1:0]     sq;
    logic [MantW:0]         s;
    logic [2*MantW-1:0]     rp;
    logic [LgW+ExpW-1:0]    pe;
    logic [ShW-1:0]         sh;

    // Special values and mantissa alignment.
    lq_d[0]      = '0;
    lq_d[0].bval = val_i;
    if (!cfg_i.gamma_en) begin
      lq_d[0].byp = 1'b1;
    end else if (cfg_i.gamma_exp == '0) begin
      lq_d[0].byp  = 1'b1;
      lq_d[0].bval = Unit;
    end else if (val_i == '0) begin
      lq_d[0].byp = 1'b1;
    end else if (val_i >= Unit) begin
      lq_d[0].byp  = 1'b1;
      lq_d[0].bval = Unit;
    end
    for (int k = 0; k < FracW; k++) begin
      if (val_i[k]) lq_d[0].pos = PosW'(k);
    end
    wide       = ((MantW+FracW)'(val_i[FracW-1:0]) << QW) >> lq_d[0].pos;
    lq_d[0].m  = wide[MantW-1:0];

    // One squaring per stage gives one bit of the log2 fraction.
    for (int k = 0; k < LogW; k++) begin
      lq_d[k+1] = lq_q[k];
      sq        = lq_q[k].m * lq_q[k].m;
      s         = sq[2*MantW-1:QW];
      if (s[MantW]) begin
        lq_d[k+1].m = s[MantW:1];
        lq_d[k+1].f = {lq_q[k].f[LogW-2:0], 1'b1};
      end else begin
        lq_d[k+1].m = s[MantW-1:0];
        lq_d[k+1].f = {lq_q[k].f[LogW-2:0], 1'b0};
      end
    end

    // Negated log2 in Q16.
    mid_d.byp  = lq_q[LogW].byp;
    mid_d.bval = lq_q[LogW].bval;
    mid_d.lg   = (LgW'(FracW - 32'(lq_q[LogW].pos)) << LogW) - LgW'(lq_q[LogW].f);

    // Scale by the exponent.
    pe         = (LgW+ExpW)'(mid_q.lg) * (LgW+ExpW)'(cfg_i.gamma_exp);
    ex_d[0].byp  = mid_q.byp;
    ex_d[0].bval = mid_q.bval;
    ex_d[0].ip   = pe[LgW+ExpW-1:12+LogW];
    ex_d[0].fp   = pe[12+LogW-1:12];
    ex_d[0].r    = OneQ;

    // exp2 of the fraction, one factor per stage.
    for (int k = 0; k < LogW; k++) begin
      ex_d[k+1] = ex_q[k];
      rp        = ex_q[k].r * FacTable[k];
      if (ex_q[k].fp[LogW-1-k]) begin
        ex_d[k+1].r = rp[QW+MantW-1:QW];
      end
    end

    // Integer part of the exponent as a right shift.
    sh = ShW'(QW - FracW) + ShW'(ex_q[LogW].ip[ShW-1:0]);
    if (ex_q[LogW].byp) begin
      out_d = ex_q[LogW].bval;
    end else if (ex_q[LogW].ip > IpW'(MantW - 1 - (QW - FracW))) begin
      out_d = '0;
    end else begin
      out_d = ValW'(ex_q[LogW].r >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lq_q  <= lq_d;
      mid_q <= mid_d;
      ex_q  <= ex_d;
      out_q <= out_d;
    end
  end

  assign val_o = out_q;

endmodule

`default_nettype wire

### design/pixel_tone_map_gamma.sv
// ----------------------------------------------------------------------------
// pixel_tone_map_gamma
// Tone mapping and optional inverse-gamma power of one RGB pixel per beat.
// ----------------------------------------------------------------------------
// A pixel beat carries three unsigned Q8.16 components and leaves as three
// 8-bit display levels. The block is a 55-stage pipeline that takes one beat
// every clock unless a result is held at the output: 18 stages for the
// largest-component search and the bit-serial normalizing divider, 36 for the
// power law (one alignment stage, 16 squaring stages for log2, one log stage,
// one multiply, 16 factor stages for exp2 and one shift stage) and one output
// register. The whole pipeline halts while a finished result is held at the
// output; bubbles move through with it.
// Configuration registers: 0x0 out-of-gamut red enable, 0x4 gamma_enable,
// 0x8 inverse_gamma (Q4.12); write them only while the pipeline is empty.
`default_nettype none

`include "pixel_tone_map_gamma_macros.svh"

module pixel_tone_map_gamma import ptmg_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // APB configuration port
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  // Pixel input stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [71:0]   s_axis_tdata,  // red_in, green_in, blue_in
  // Level output stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic      [23:0]   m_axis_tdata   // red_out, green_out, blue_out
);

  cfg_t                   cfg_q;
  logic [PipeDepth-1:0]   valid_q;
  logic                   en;
  logic [ValW-1:0]        nr, ng, nb;
  logic [2:0][ValW-1:0]   pw;
  logic [2:0][LevelW-1:0] lvl_q, lvl_d;

  // Register file.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.show_oog  <= 1'b0;
      cfg_q.gamma_en  <= 1'b0;
      cfg_q.gamma_exp <= InvGammaReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[3:2]))
        RegShowOog:  cfg_q.show_oog  <= pwdata[0];
        RegGammaEn:  cfg_q.gamma_en  <= pwdata[0];
        RegInvGamma: cfg_q.gamma_exp <= pwdata[ExpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      RegShowOog:  prdata = {31'b0, cfg_q.show_oog};
      RegGammaEn:  prdata = {31'b0, cfg_q.gamma_en};
      RegInvGamma: prdata = {{(32-ExpW){1'b0}}, cfg_q.gamma_exp};
      default:     prdata = '0;
    endcase
  end

  // Pipeline advance and valid line.
  assign en            = !valid_q[PipeDepth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PipeDepth-2:0], s_axis_tvalid};
    end
  end

  ptmg_norm u_norm (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .red_i   (s_axis_tdata[CompW-1:0]),
    .green_i (s_axis_tdata[2*CompW-1:CompW]),
    .blue_i  (s_axis_tdata[3*CompW-1:2*CompW]),
    .red_o   (nr),
    .green_o (ng),
    .blue_o  (nb)
  );

  ptmg_power u_pow_r (.clk_i(clk_i), .en_i(en), .cfg_i(cfg_q), .val_i(nr), .val_o(pw[0]));
  ptmg_power u_pow_g (.clk_i(clk_i), .en_i(en), .cfg_i(cfg_q), .val_i(ng), .val_o(pw[1]));
  ptmg_power u_pow_b (.clk_i(clk_i), .en_i(en), .cfg_i(cfg_q), .val_i(nb), .val_o(pw[2]));

  // Scale by 255 and saturate.
  always_comb begin
    logic [ValW+LevelW-1:0] sc;
    for (int i = 0; i < 3; i++) begin
      sc = ((ValW+LevelW)'(pw[i]) << LevelW) - (ValW+LevelW)'(pw[i]);
      if (sc[ValW+LevelW-1:FracW] > (ValW+LevelW-FracW)'(255)) begin
        lvl_d[i] = '1;
      end else begin
        lvl_d[i] = sc[FracW+LevelW-1:FracW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lvl_q <= lvl_d;
    end
  end

  assign m_axis_tdata = lvl_q;

  // Checks on the pipeline control.
  `PTMG_ASSERT_NEXT(a_fire_enters, s_axis_tvalid && s_axis_tready, valid_q[0],
                    "accepted beat did not enter the pipeline")
  `PTMG_ASSERT_NEXT(a_stall_holds, !en, $stable(valid_q),
                    "valid line moved during a stall")
  `PTMG_ASSERT_NEXT(a_one_in, 1'b1,
                    $countones(valid_q) <= $past($countones(valid_q)) + 1,
                    "more than one beat entered in a cycle")
  `PTMG_ASSERT_NOW(a_ready_free, !m_axis_tvalid, s_axis_tready,
                   "input blocked while output is empty")

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for pixel_tone_map_gamma
// Drives pixel beats and APB register writes, predicts each level beat with a
// fixed-point model of the tone map and power law, and checks every field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import ptmg_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LimitCycles = 400000;
  localparam int DrainCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // red_in, green_in, blue_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // red_out, green_out, blue_out

  // Local copy of the configuration.
  logic        oog_mode;
  logic        gamma_on;
  logic [15:0] gamma_exp;

  logic [23:0] level_queue[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          sink_stall_on = 1'b0;

  pixel_tone_map_gamma uut (.*);

  always #5 clk_i = ~clk_i;

  // Run timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] rem, res, bt;
    rem = x;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Power law v^(e/4096) through log2 squaring and an exp2 factor product.
  function automatic logic [63:0] gamma_power(input logic [63:0] v, input logic [15:0] e);
    logic [63:0] mant, lfrac, lg, prod, ip, fp, r, sh;
    logic [63:0] fac[16];
    int          msb;
    if (e == 0) return 64'd1 << 16;
    if (v == 0) return 0;
    if (v >= (64'd1 << 16)) return 64'd1 << 16;
    msb = 0;
    for (int k = 0; k < 16; k++) if (v[k]) msb = k;
    mant = v << (30 - msb);
    lfrac = 0;
    for (int k = 0; k < 16; k++) begin
      mant = (mant * mant) >> 30;
      lfrac = lfrac << 1;
      if (mant >= (64'd2 << 30)) begin
        lfrac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    lg = (64'(16 - msb) << 16) - lfrac;
    prod = (lg * 64'(e)) >> 12;
    ip = prod >> 16;
    fp = prod & 64'hFFFF;
    fac[0] = int_root(64'd1 << 59);
    for (int k = 1; k < 16; k++) fac[k] = int_root(fac[k-1] << 30);
    r = 64'd1 << 30;
    for (int k = 0; k < 16; k++) if (fp[15-k]) r = (r * fac[k]) >> 30;
    sh = 64'd14 + ip;
    if (sh >= 64) return 0;
    return r >> sh;
  endfunction

  // Expected display levels of one pixel.
  function automatic logic [23:0] pixel_levels(input logic [71:0] px);
    logic [63:0] c[3];
    logic [63:0] mx, lvl;
    logic [23:0] res;
    for (int i = 0; i < 3; i++) c[i] = 64'(px[24*i +: 24]);
    mx = c[0];
    if (c[1] > mx) mx = c[1];
    if (c[2] > mx) mx = c[2];
    if (oog_mode) begin
      if (mx > 64'h10000) begin
        c[0] = 64'h10000;
        c[1] = 0;
        c[2] = 0;
      end
    end else if (mx > 64'h10000) begin
      for (int i = 0; i < 3; i++) c[i] = (c[i] << 16) / mx;
    end
    for (int i = 0; i < 3; i++) begin
      if (gamma_on) c[i] = gamma_power(c[i], gamma_exp);
      lvl = (c[i] * 255) >> 16;
      res[8*i +: 8] = (lvl > 255) ? 8'd255 : lvl[7:0];
    end
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // Sink: random stalls, compare each level beat with the oldest prediction.
  always @(posedge clk_i) begin
    logic [23:0] exp_lv;
    if (m_axis_tvalid && m_axis_tready) begin
      if (level_queue.size() == 0) begin
        $error("unexpected level beat %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_lv = level_queue.pop_front();
        if (m_axis_tdata[7:0] !== exp_lv[7:0]) begin
          $error("red_out expected %0d actual %0d", exp_lv[7:0], m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[15:8] !== exp_lv[15:8]) begin
          $error("green_out expected %0d actual %0d", exp_lv[15:8], m_axis_tdata[15:8]);
          fail_count++;
        end
        if (m_axis_tdata[23:16] !== exp_lv[23:16]) begin
          $error("blue_out expected %0d actual %0d", exp_lv[23:16], m_axis_tdata[23:16]);
          fail_count++;
        end
      end
    end
    if (rst_ni) m_axis_tready <= sink_stall_on ? ($urandom_range(3) != 0) : 1'b1;
  end

  // Stall pattern switches now and then so both long and gap-free runs occur.
  always @(posedge clk_i) if ($urandom_range(199) == 0) sink_stall_on <= ~sink_stall_on;

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegShowOog:  oog_mode = val[0];
      RegGammaEn:  gamma_on = val[0];
      RegInvGamma: gamma_exp = val[15:0];
      default: ;
    endcase
  endtask

  // Send one pixel beat, with an optional gap ahead of it.
  task automatic send_pixel(input logic [71:0] px, input bit with_gap);
    int gap;
    gap = with_gap ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    level_queue.push_back(pixel_levels(px));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    while (level_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_comp();
    case ($urandom_range(5))
      0: return 24'($urandom_range(65536));
      1: return 24'($urandom_range(255));
      2: return 24'h010000;
      3: return 24'($urandom_range(65536, 131072));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [23:0] vals[8];
    vals = '{24'h0, 24'h1, 24'hFFFF, 24'h10000, 24'h10001, 24'hFFFFFF, 24'h800000, 24'h8000};
    write_reg(RegShowOog, 0);
    write_reg(RegGammaEn, 1);
    write_reg(RegInvGamma, 32'h0000_0000);
    for (int i = 0; i < 8; i++) send_pixel({vals[i], vals[(i+3)%8], vals[(i+5)%8]}, 0);
    end_burst();
    write_reg(RegInvGamma, 32'hFFFF_FFFF);
    write_reg(RegShowOog, 1);
    for (int i = 0; i < 8; i++) send_pixel({vals[(i+1)%8], vals[i], vals[(i+6)%8]}, 0);
    end_burst();
    write_reg(RegGammaEn, 0);
    for (int i = 0; i < 8; i++) send_pixel({vals[i], vals[(i+2)%8], vals[(i+7)%8]}, 0);
    end_burst();
  endtask

  task automatic test_random_phase(input logic oog, input logic gen, input logic [15:0] ig,
                                   input int count);
    write_reg(RegShowOog, 32'(oog));
    write_reg(RegGammaEn, 32'(gen));
    write_reg(RegInvGamma, 32'(ig));
    for (int i = 0; i < count; i++) send_pixel({rand_comp(), rand_comp(), rand_comp()}, 1);
    end_burst();
  endtask

  initial begin
    oog_mode = 1'b0;
    gamma_on = 1'b0;
    gamma_exp = 16'd4096;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset configuration first.
    for (int i = 0; i < 40; i++) send_pixel({rand_comp(), rand_comp(), rand_comp()}, 1);
    end_burst();
    test_directed();
    test_random_phase(0, 1, 16'd1820, 120);
    test_random_phase(1, 1, 16'd9011, 100);
    test_random_phase(0, 0, 16'd4096, 100);
    test_random_phase(1, 0, 16'd0, 80);
    test_random_phase(0, 1, 16'hFFFF, 80);
    test_random_phase(1, 1, 16'd1, 70);
    test_random_phase(0, 1, 16'($urandom), 80);
    test_random_phase(1, 1, 16'($urandom), 60);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/ptmg_pkg.sv
design/ptmg_norm.sv
design/ptmg_power.sv
design/pixel_tone_map_gamma.sv
bench/tb_top.sv
